[hw/rtl/climate_threshold_scheduler_top_defines.svh]
// ----------------------------------------------------------------------------
// Climate threshold scheduler assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CLIMATE_THRESHOLD_SCHEDULER_TOP_DEFINES_SVH
`define CLIMATE_THRESHOLD_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication
`define CTS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cts assertion failed");

// next-cycle implication
`define CTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cts assertion failed");

`endif

[hw/rtl/cts_pkg.sv]
// ----------------------------------------------------------------------------
// Climate threshold scheduler package
// Field widths, channel and command codes, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package cts_pkg;

    localparam int TempW  = 15;
    localparam int HumidW = 14;
    localparam int MinW   = 11;
    localparam int CmdW   = 2;
    localparam int ChanW  = 3;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 15;
    localparam int NumChannels = 6;
    localparam int QueueDepth  = 2;

    localparam logic [ChanW-1:0] CH_TEMP_HIGH  = 3'd0;
    localparam logic [ChanW-1:0] CH_TEMP_LOW   = 3'd1;
    localparam logic [ChanW-1:0] CH_HUMID_HIGH = 3'd2;
    localparam logic [ChanW-1:0] CH_HUMID_LOW  = 3'd3;
    localparam logic [ChanW-1:0] CH_LIGHT      = 3'd4;
    localparam logic [ChanW-1:0] CH_WATER      = 3'd5;

    localparam logic [CmdW-1:0] CMD_VENT  = 2'd0;
    localparam logic [CmdW-1:0] CMD_HEAT  = 2'd1;
    localparam logic [CmdW-1:0] CMD_LIGHT = 2'd2;
    localparam logic [CmdW-1:0] CMD_PUMP  = 2'd3;

    localparam logic [CfgIdxW-1:0] REG_TEMP_HIGH   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_TEMP_LOW    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_HUMID_HIGH  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_HUMID_LOW   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_LIGHT_START = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_LIGHT_LEN   = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_WATER_START = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_WATER_LEN   = 3'd7;

    typedef struct packed {
        logic [NumChannels-1:0] trig;
        logic [NumChannels-1:0] rel;
    } cls_t;

    typedef struct packed {
        logic [CmdW-1:0]  actuator_cmd;
        logic [ChanW-1:0] source_channel;
    } cmd_t;

    function automatic logic [CmdW-1:0] chan_cmd(input logic [ChanW-1:0] ch);
        logic [CmdW-1:0] cmd;
        case (ch)
            CH_TEMP_HIGH:  cmd = CMD_VENT;
            CH_TEMP_LOW:   cmd = CMD_HEAT;
            CH_HUMID_HIGH: cmd = CMD_VENT;
            CH_HUMID_LOW:  cmd = CMD_HEAT;
            CH_LIGHT:      cmd = CMD_LIGHT;
            CH_WATER:      cmd = CMD_PUMP;
            default:       cmd = CMD_VENT;
        endcase
        return cmd;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/cts_sample_if.sv]
// ----------------------------------------------------------------------------
// Sample channel interface
// Valid/ready channel carrying one sensor sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface cts_sample_if;
    logic                               valid;
    logic                               ready;
    logic signed [cts_pkg::TempW-1:0]   temperature;
    logic [cts_pkg::HumidW-1:0]         humidity;
    logic [cts_pkg::MinW-1:0]           minute_of_day;

    modport source (output valid, output temperature, output humidity,
                    output minute_of_day, input ready);
    modport sink   (input valid, input temperature, input humidity,
                    input minute_of_day, output ready);
endinterface

`default_nettype wire

[hw/rtl/cts_result_if.sv]
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying one toggle command.
// ----------------------------------------------------------------------------
`default_nettype none

interface cts_result_if;
    logic                        valid;
    logic                        ready;
    logic [cts_pkg::CmdW-1:0]    actuator_cmd;
    logic [cts_pkg::ChanW-1:0]   source_channel;
    logic                        last_of_run;

    modport source (output valid, output actuator_cmd, output source_channel,
                    output last_of_run, input ready);
    modport sink   (input valid, input actuator_cmd, input source_channel,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

[hw/rtl/climate_threshold_scheduler_top.sv]
// A sample is registered in the front end, queued, then walked by the back end, which
// takes a new sample only when idle: it loads the sample, steps through the channels in
// order (again after a latch entry, held while the result side stalls), then flushes any pending command.
// A two-deep queue lets the front end take samples while the walk runs.
// Reset: rst_n async active low; limits return to defaults, all latches clear.
// ----------------------------------------------------------------------------
// Climate threshold scheduler top level
// Six-channel threshold and time-of-day scheduler emitting toggle commands.
// ----------------------------------------------------------------------------
`default_nettype none

module climate_threshold_scheduler_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [cts_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [cts_pkg::CfgDataW-1:0] cfg_data,
    cts_sample_if.sink                        sample,
    cts_result_if.source                      result
);

    logic          cls_valid;
    logic          cls_ready;
    cts_pkg::cls_t cls_data;
    logic          q_valid;
    logic          q_ready;
    cts_pkg::cls_t q_data;

    cts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .cls_valid (cls_valid),
        .cls_ready (cls_ready),
        .cls_data  (cls_data)
    );

    cts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cls_valid),
        .in_ready  (cls_ready),
        .in_data   (cls_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    cts_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .result  (result)
    );

endmodule

`default_nettype wire

[hw/rtl/cts_front.sv]
// ----------------------------------------------------------------------------
// Scheduler front end
// Holds the limit registers and turns each sample into trigger and release
// flags for all six channels, registered toward the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cts_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [cts_pkg::CfgIdxW-1:0]      cfg_index,
    input  wire logic [cts_pkg::CfgDataW-1:0]     cfg_data,
    cts_sample_if.sink                            sample,
    output logic                                  cls_valid,
    input  wire logic                             cls_ready,
    output cts_pkg::cls_t                         cls_data
);

    logic signed [cts_pkg::TempW-1:0] temp_high_reg;
    logic signed [cts_pkg::TempW-1:0] temp_low_reg;
    logic [cts_pkg::HumidW-1:0]       humid_high_reg;
    logic [cts_pkg::HumidW-1:0]       humid_low_reg;
    logic [cts_pkg::MinW-1:0]         light_start_reg;
    logic [cts_pkg::MinW-1:0]         light_len_reg;
    logic [cts_pkg::MinW-1:0]         water_start_reg;
    logic [cts_pkg::MinW-1:0]         water_len_reg;

    logic                             cls_valid_reg;
    cts_pkg::cls_t                    cls_reg;
    cts_pkg::cls_t                    cls_next;
    logic [cts_pkg::MinW:0]           light_end;
    logic [cts_pkg::MinW:0]           water_end;
    logic [cts_pkg::MinW:0]           minute_ext;
    logic                             take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_high_reg   <= 15'sd3000;
            temp_low_reg    <= 15'sd1500;
            humid_high_reg  <= 14'd8000;
            humid_low_reg   <= 14'd4000;
            light_start_reg <= 11'd360;
            light_len_reg   <= 11'd720;
            water_start_reg <= 11'd480;
            water_len_reg   <= 11'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cts_pkg::REG_TEMP_HIGH:   temp_high_reg   <= cfg_data;
                cts_pkg::REG_TEMP_LOW:    temp_low_reg    <= cfg_data;
                cts_pkg::REG_HUMID_HIGH:  humid_high_reg  <= cfg_data[cts_pkg::HumidW-1:0];
                cts_pkg::REG_HUMID_LOW:   humid_low_reg   <= cfg_data[cts_pkg::HumidW-1:0];
                cts_pkg::REG_LIGHT_START: light_start_reg <= cfg_data[cts_pkg::MinW-1:0];
                cts_pkg::REG_LIGHT_LEN:   light_len_reg   <= cfg_data[cts_pkg::MinW-1:0];
                cts_pkg::REG_WATER_START: water_start_reg <= cfg_data[cts_pkg::MinW-1:0];
                cts_pkg::REG_WATER_LEN:   water_len_reg   <= cfg_data[cts_pkg::MinW-1:0];
                default:                  ;
            endcase
        end
    end

    // end minute is not wrapped: a sum above 2047 never matches an 11-bit minute
    assign light_end  = {1'b0, light_start_reg} + {1'b0, light_len_reg};
    assign water_end  = {1'b0, water_start_reg} + {1'b0, water_len_reg};
    assign minute_ext = {1'b0, sample.minute_of_day};

    always_comb
    begin
        cls_next.trig[cts_pkg::CH_TEMP_HIGH]  = sample.temperature >= temp_high_reg;
        cls_next.rel[cts_pkg::CH_TEMP_HIGH]   = sample.temperature <  temp_high_reg;
        cls_next.trig[cts_pkg::CH_TEMP_LOW]   = sample.temperature <= temp_low_reg;
        cls_next.rel[cts_pkg::CH_TEMP_LOW]    = sample.temperature >  temp_low_reg;
        cls_next.trig[cts_pkg::CH_HUMID_HIGH] = sample.humidity >= humid_high_reg;
        cls_next.rel[cts_pkg::CH_HUMID_HIGH]  = sample.humidity <  humid_high_reg;
        cls_next.trig[cts_pkg::CH_HUMID_LOW]  = sample.humidity <= humid_low_reg;
        cls_next.rel[cts_pkg::CH_HUMID_LOW]   = sample.humidity >  humid_low_reg;
        cls_next.trig[cts_pkg::CH_LIGHT]      = sample.minute_of_day == light_start_reg;
        cls_next.rel[cts_pkg::CH_LIGHT]       = minute_ext == light_end;
        cls_next.trig[cts_pkg::CH_WATER]      = sample.minute_of_day == water_start_reg;
        cls_next.rel[cts_pkg::CH_WATER]       = minute_ext == water_end;
    end

    assign sample.ready = !cls_valid_reg || cls_ready;
    assign take         = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            cls_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cls_reg <= cls_next;
        end
    end

    assign cls_valid = cls_valid_reg;
    assign cls_data  = cls_reg;

endmodule

`default_nettype wire

[hw/rtl/cts_queue.sv]
// ----------------------------------------------------------------------------
// Scheduler queue
// Short FIFO of classified samples between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module cts_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire cts_pkg::cls_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output cts_pkg::cls_t       out_data
);

    localparam int PtrW = $clog2(cts_pkg::QueueDepth);
    localparam int CntW = $clog2(cts_pkg::QueueDepth + 1);

    cts_pkg::cls_t   entry_reg [cts_pkg::QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            push;
    logic            pop;

    assign in_ready  = count_reg != CntW'(cts_pkg::QueueDepth);
    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(cts_pkg::QueueDepth - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(cts_pkg::QueueDepth - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/cts_back.sv]
// ----------------------------------------------------------------------------
// Scheduler back end
// Walks the six channels of one sample in order, keeps the latch state and
// emits toggle commands through a one-deep hold and an output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "climate_threshold_scheduler_top_defines.svh"

module cts_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire cts_pkg::cls_t  q_data,
    cts_result_if.source        result
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_WALK,
        B_FLUSH
    } back_state_t;

    localparam logic [cts_pkg::ChanW-1:0] LastChan =
        cts_pkg::ChanW'(cts_pkg::NumChannels - 1);

    back_state_t                     state_reg;
    cts_pkg::cls_t                   item_reg;
    logic [cts_pkg::ChanW-1:0]       chan_reg;
    logic [cts_pkg::NumChannels-1:0] latched_reg;
    logic                            pend_valid_reg;
    cts_pkg::cmd_t                   pend_reg;
    logic                            out_valid_reg;
    cts_pkg::cmd_t                   out_reg;
    logic                            out_last_reg;

    logic [cts_pkg::NumChannels-1:0] chan_bit;
    logic                            lat_c;
    logic                            others_free;
    logic                            active;
    logic                            do_entry;
    logic                            do_rel;
    logic                            emit;
    logic                            slot_free;
    logic                            stall;

    assign chan_bit    = cts_pkg::NumChannels'(1) << chan_reg;
    assign lat_c       = latched_reg[chan_reg];
    assign others_free = (latched_reg & ~chan_bit) == '0;
    assign active      = (item_reg.trig[chan_reg] || lat_c) && others_free;
    assign do_entry    = active && !lat_c;
    assign do_rel      = active && lat_c && item_reg.rel[chan_reg];
    assign emit        = do_entry || do_rel;
    assign slot_free   = !out_valid_reg || result.ready;
    assign stall       = emit && pend_valid_reg && !slot_free;
    assign q_ready     = state_reg == B_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            chan_reg       <= '0;
            latched_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg  <= q_data;
                        chan_reg  <= '0;
                        state_reg <= B_WALK;
                    end
                end
                B_WALK:
                begin
                    if (!stall)
                    begin
                        if (emit)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_reg       <= pend_reg;
                                out_last_reg  <= 1'b0;
                                out_valid_reg <= 1'b1;
                            end
                            pend_reg.actuator_cmd   <= cts_pkg::chan_cmd(chan_reg);
                            pend_reg.source_channel <= chan_reg;
                            pend_valid_reg          <= 1'b1;
                        end
                        if (do_entry)
                        begin
                            // hold the channel to test its release next cycle
                            latched_reg[chan_reg] <= 1'b1;
                        end
                        else
                        begin
                            if (do_rel)
                            begin
                                latched_reg[chan_reg] <= 1'b0;
                            end
                            if (chan_reg == LastChan)
                            begin
                                state_reg <= (pend_valid_reg || emit) ? B_FLUSH : B_IDLE;
                            end
                            else
                            begin
                                chan_reg <= chan_reg + 1'b1;
                            end
                        end
                    end
                end
                B_FLUSH:
                begin
                    if (slot_free)
                    begin
                        out_reg        <= pend_reg;
                        out_last_reg   <= 1'b1;
                        out_valid_reg  <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.actuator_cmd   = out_reg.actuator_cmd;
    assign result.source_channel = out_reg.source_channel;
    assign result.last_of_run    = out_last_reg;

    `CTS_ASSERT_SAME(a_latch_onehot, 1'b1, $onehot0(latched_reg))
    `CTS_ASSERT_SAME(a_chan_range, state_reg == B_WALK, chan_reg <= LastChan)
    `CTS_ASSERT_NEXT(a_entry_latches, state_reg == B_WALK && do_entry && !stall,
        latched_reg == $past(latched_reg | chan_bit) && state_reg == B_WALK)
    `CTS_ASSERT_SAME(a_idle_no_pending, state_reg == B_IDLE, !pend_valid_reg)
    `CTS_ASSERT_NEXT(a_flush_last, state_reg == B_FLUSH && slot_free,
        out_valid_reg && out_last_reg && state_reg == B_IDLE)

endmodule

`default_nettype wire

[tb/sv/tb_climate_threshold_scheduler_top.sv]
// ----------------------------------------------------------------------------
// Climate threshold scheduler testbench
// Drives sensor samples and register settings into the scheduler, predicts
// the toggle commands of all six channels and checks every command in order.
// Directed samples cover thresholds, field extremes, zero-length programs and
// program ends past midnight; biased random samples follow under several
// settings, with random idling on both channels, a long result stall and a
// pause of the sample stream until all commands have drained.
// ----------------------------------------------------------------------------
typedef struct packed {
    logic [cts_pkg::CmdW-1:0]  actuator_cmd;
    logic [cts_pkg::ChanW-1:0] source_channel;
    logic                      last_of_run;
} toggle_cmd_t;

class toggle_tracker;
    logic signed [cts_pkg::TempW-1:0] temp_high;
    logic signed [cts_pkg::TempW-1:0] temp_low;
    logic [cts_pkg::HumidW-1:0]       humid_high;
    logic [cts_pkg::HumidW-1:0]       humid_low;
    logic [cts_pkg::MinW-1:0]         light_start;
    logic [cts_pkg::MinW-1:0]         light_len;
    logic [cts_pkg::MinW-1:0]         water_start;
    logic [cts_pkg::MinW-1:0]         water_len;
    logic [cts_pkg::NumChannels-1:0]  latched;
    logic [cts_pkg::CmdW-1:0]         actuator_of [cts_pkg::NumChannels];
    toggle_cmd_t                      pending_cmds [$];
    int unsigned                      faults;
    int unsigned                      samples_seen;
    int unsigned                      cmds_checked;

    function new();
        temp_high   = 3000;
        temp_low    = 1500;
        humid_high  = 8000;
        humid_low   = 4000;
        light_start = 360;
        light_len   = 720;
        water_start = 480;
        water_len   = 10;
        latched     = '0;
        actuator_of = '{cts_pkg::CMD_VENT, cts_pkg::CMD_HEAT, cts_pkg::CMD_VENT,
                        cts_pkg::CMD_HEAT, cts_pkg::CMD_LIGHT, cts_pkg::CMD_PUMP};
        faults       = 0;
        samples_seen = 0;
        cmds_checked = 0;
    endfunction

    function void set_limit(input logic [cts_pkg::CfgIdxW-1:0] idx,
                            input logic [cts_pkg::CfgDataW-1:0] data);
        case (idx)
            cts_pkg::REG_TEMP_HIGH:   temp_high   = data[cts_pkg::TempW-1:0];
            cts_pkg::REG_TEMP_LOW:    temp_low    = data[cts_pkg::TempW-1:0];
            cts_pkg::REG_HUMID_HIGH:  humid_high  = data[cts_pkg::HumidW-1:0];
            cts_pkg::REG_HUMID_LOW:   humid_low   = data[cts_pkg::HumidW-1:0];
            cts_pkg::REG_LIGHT_START: light_start = data[cts_pkg::MinW-1:0];
            cts_pkg::REG_LIGHT_LEN:   light_len   = data[cts_pkg::MinW-1:0];
            cts_pkg::REG_WATER_START: water_start = data[cts_pkg::MinW-1:0];
            cts_pkg::REG_WATER_LEN:   water_len   = data[cts_pkg::MinW-1:0];
            default:                  ;
        endcase
    endfunction

    function void take_sample(input logic signed [cts_pkg::TempW-1:0] t,
                              input logic [cts_pkg::HumidW-1:0] h,
                              input logic [cts_pkg::MinW-1:0] m);
        logic [cts_pkg::NumChannels-1:0] trig;
        logic [cts_pkg::NumChannels-1:0] rel;
        logic [cts_pkg::NumChannels-1:0] others;
        logic [cts_pkg::MinW:0]          light_end;
        logic [cts_pkg::MinW:0]          water_end;
        logic                            held;
        toggle_cmd_t                     entry;
        toggle_cmd_t                     run [$];

        light_end = {1'b0, light_start} + {1'b0, light_len};
        water_end = {1'b0, water_start} + {1'b0, water_len};
        trig[cts_pkg::CH_TEMP_HIGH]  = t >= temp_high;
        rel[cts_pkg::CH_TEMP_HIGH]   = t < temp_high;
        trig[cts_pkg::CH_TEMP_LOW]   = t <= temp_low;
        rel[cts_pkg::CH_TEMP_LOW]    = t > temp_low;
        trig[cts_pkg::CH_HUMID_HIGH] = h >= humid_high;
        rel[cts_pkg::CH_HUMID_HIGH]  = h < humid_high;
        trig[cts_pkg::CH_HUMID_LOW]  = h <= humid_low;
        rel[cts_pkg::CH_HUMID_LOW]   = h > humid_low;
        trig[cts_pkg::CH_LIGHT]      = m == light_start;
        rel[cts_pkg::CH_LIGHT]       = {1'b0, m} == light_end;
        trig[cts_pkg::CH_WATER]      = m == water_start;
        rel[cts_pkg::CH_WATER]       = {1'b0, m} == water_end;

        for (int c = 0; c < cts_pkg::NumChannels; c++)
        begin
            held      = latched[c];
            others    = latched;
            others[c] = 1'b0;
            entry.actuator_cmd   = actuator_of[c];
            entry.source_channel = cts_pkg::ChanW'(c);
            entry.last_of_run    = 1'b0;
            if ((trig[c] || held) && others == '0)
            begin
                if (!held)
                begin
                    latched[c] = 1'b1;
                    run.push_back(entry);
                end
                if (rel[c])
                begin
                    latched[c] = 1'b0;
                    run.push_back(entry);
                end
            end
        end
        if (run.size() > 0)
            run[run.size()-1].last_of_run = 1'b1;
        foreach (run[i])
            pending_cmds.push_back(run[i]);
        samples_seen++;
    endfunction

    function void match_command(input logic [cts_pkg::CmdW-1:0] cmd,
                                input logic [cts_pkg::ChanW-1:0] chan,
                                input logic last);
        toggle_cmd_t want;

        if (pending_cmds.size() == 0)
        begin
            faults++;
            $display("%0t: unexpected command: expected none, actual cmd %0d chan %0d last %0d",
                     $time, cmd, chan, last);
            return;
        end
        want = pending_cmds.pop_front();
        cmds_checked++;
        if (want.actuator_cmd !== cmd)
        begin
            faults++;
            $display("%0t: actuator_cmd mismatch: expected %0d actual %0d",
                     $time, want.actuator_cmd, cmd);
        end
        if (want.source_channel !== chan)
        begin
            faults++;
            $display("%0t: source_channel mismatch: expected %0d actual %0d",
                     $time, want.source_channel, chan);
        end
        if (want.last_of_run !== last)
        begin
            faults++;
            $display("%0t: last_of_run mismatch: expected %0d actual %0d",
                     $time, want.last_of_run, last);
        end
    endfunction
endclass

module tb_climate_threshold_scheduler_top;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [cts_pkg::CfgIdxW-1:0]  cfg_index;
    logic [cts_pkg::CfgDataW-1:0] cfg_data;

    cts_sample_if sample ();
    cts_result_if result ();

    climate_threshold_scheduler_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .result    (result)
    );

    toggle_tracker tracker = new();

    bit idle_on = 1'b1;
    bit rx_hold = 1'b0;
    int burst_left = 0;
    int settings_loaded = 0;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin : result_sink
        int stall;

        result.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 15) : 0;
            if (rx_hold)
            begin
                stall   = 300;
                rx_hold = 1'b0;
            end
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            do @(posedge clk); while (result.valid !== 1'b1);
            tracker.match_command(result.actuator_cmd, result.source_channel,
                                  result.last_of_run);
        end
    end

    initial
    begin
        #5000000;
        $display("climate_threshold_scheduler_top test failed");
        $finish;
    end

    task automatic send_sample(input logic signed [cts_pkg::TempW-1:0] t,
                               input logic [cts_pkg::HumidW-1:0] h,
                               input logic [cts_pkg::MinW-1:0] m);
        int gap;

        gap = (idle_on && burst_left == 0) ? $urandom_range(0, 15) : 0;
        if (burst_left > 0)
            burst_left--;
        if (gap > 0)
        begin
            sample.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample.valid         <= 1'b1;
        sample.temperature   <= t;
        sample.humidity      <= h;
        sample.minute_of_day <= m;
        do @(posedge clk); while (sample.ready !== 1'b1);
        tracker.take_sample(t, h, m);
    endtask

    task automatic random_sample();
        int t;
        int h;
        int m;

        if ($urandom_range(0, 99) < 12)
        begin
            t = $urandom;
            h = $urandom;
            m = $urandom;
        end
        else
        begin
            case ($urandom_range(0, 7))
                0, 1, 2: t = int'(tracker.temp_high) + int'($urandom_range(0, 4)) - 2;
                3, 4, 5: t = int'(tracker.temp_low) + int'($urandom_range(0, 4)) - 2;
                default: t = int'($urandom_range(0, 20000)) - 5000;
            endcase
            case ($urandom_range(0, 7))
                0, 1, 2: h = int'(tracker.humid_high) + int'($urandom_range(0, 4)) - 2;
                3, 4, 5: h = int'(tracker.humid_low) + int'($urandom_range(0, 4)) - 2;
                default: h = $urandom_range(0, 10000);
            endcase
            case ($urandom_range(0, 9))
                0, 1:    m = tracker.light_start;
                2, 3:    m = int'(tracker.light_start) + int'(tracker.light_len);
                4, 5:    m = tracker.water_start;
                6, 7:    m = int'(tracker.water_start) + int'(tracker.water_len);
                default: m = $urandom_range(0, 1439);
            endcase
        end
        send_sample(cts_pkg::TempW'(t), cts_pkg::HumidW'(h), cts_pkg::MinW'(m));
    endtask

    task automatic drain_cmds(input int settle);
        sample.valid <= 1'b0;
        while (tracker.pending_cmds.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [cts_pkg::CfgIdxW-1:0] idx,
                             input logic [cts_pkg::CfgDataW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.set_limit(idx, data);
    endtask

    task automatic load_settings(input int th, input int tl, input int hh, input int hl,
                                 input int ls, input int ll, input int ws, input int wl);
        write_reg(cts_pkg::REG_TEMP_HIGH,   cts_pkg::CfgDataW'(th));
        write_reg(cts_pkg::REG_TEMP_LOW,    cts_pkg::CfgDataW'(tl));
        write_reg(cts_pkg::REG_HUMID_HIGH,  cts_pkg::CfgDataW'(hh));
        write_reg(cts_pkg::REG_HUMID_LOW,   cts_pkg::CfgDataW'(hl));
        write_reg(cts_pkg::REG_LIGHT_START, cts_pkg::CfgDataW'(ls));
        write_reg(cts_pkg::REG_LIGHT_LEN,   cts_pkg::CfgDataW'(ll));
        write_reg(cts_pkg::REG_WATER_START, cts_pkg::CfgDataW'(ws));
        write_reg(cts_pkg::REG_WATER_LEN,   cts_pkg::CfgDataW'(wl));
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    initial
    begin
        int tl;
        int hl;
        int lens [2];

        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= cts_pkg::REG_TEMP_HIGH;
        cfg_data             <= '0;
        sample.valid         <= 1'b0;
        sample.temperature   <= '0;
        sample.humidity      <= '0;
        sample.minute_of_day <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // threshold entry and release of every channel under default limits
        send_sample(2000, 6000, 0);
        send_sample(3000, 6000, 0);
        send_sample(3500, 6000, 360);
        send_sample(2999, 6000, 0);
        send_sample(1500, 6000, 0);
        send_sample(1501, 6000, 0);
        send_sample(2000, 8000, 0);
        send_sample(2000, 7999, 0);
        send_sample(2000, 4000, 0);
        send_sample(2000, 4001, 0);
        send_sample(2000, 6000, 360);
        send_sample(2000, 6000, 1080);
        send_sample(2000, 6000, 480);
        send_sample(2000, 6000, 490);
        drain_cmds(48);

        // zero-length programs sharing a start: up to five commands per sample
        load_settings(3000, 1500, 8000, 4000, 700, 0, 700, 0);
        send_sample(3200, 6000, 0);
        send_sample(2000, 6000, 700);
        send_sample(1000, 9000, 700);
        send_sample(2000, 6000, 0);
        send_sample(-16384, 0, 2047);
        send_sample(16383, 16383, 2047);
        send_sample(2000, 6000, 700);
        send_sample(2000, 16383, 0);
        send_sample(2000, 0, 0);
        send_sample(2000, 6000, 0);
        drain_cmds(48);

        // light program end past midnight never matches
        load_settings(3000, 1500, 8000, 4000, 1439, 1000, 480, 10);
        send_sample(2000, 6000, 1439);
        send_sample(2000, 6000, 391);
        send_sample(2000, 6000, 2047);
        drain_cmds(48);

        for (int p = 0; p < 8; p++)
        begin
            if (p == 0)
                load_settings(-5000, -5000, 0, 0, 0, 0, 0, 0);
            else if (p == 1)
                load_settings(15000, 15000, 10000, 10000, 1439, 1439, 1439, 1439);
            else
            begin
                tl = int'($urandom_range(0, 15000)) - 5000;
                hl = $urandom_range(0, 8000);
                foreach (lens[i])
                    case ($urandom_range(0, 3))
                        0:       lens[i] = 0;
                        1, 2:    lens[i] = $urandom_range(1, 30);
                        default: lens[i] = $urandom_range(0, 1439);
                    endcase
                load_settings(tl + int'($urandom_range(0, 5000)), tl,
                              hl + int'($urandom_range(0, 2000)), hl,
                              $urandom_range(0, 1439), lens[0],
                              $urandom_range(0, 1439), lens[1]);
            end
            idle_on = (p % 3 != 2);
            for (int n = 0; n < 40; n++)
            begin
                if ((p == 3 || p == 6) && n == 5)
                begin
                    rx_hold    = 1'b1;
                    burst_left = 14;
                end
                if (p == 4 && n == 20)
                    drain_cmds(1);
                random_sample();
            end
            drain_cmds(48);
        end

        if (tracker.pending_cmds.size() != 0)
        begin
            tracker.faults++;
            $display("%0t: %0d commands expected but never seen",
                     $time, tracker.pending_cmds.size());
        end
        $display("Covered %0d samples and %0d checked commands over %0d register settings",
                 tracker.samples_seen, tracker.cmds_checked, settings_loaded);
        if (tracker.faults == 0)
            $display("climate_threshold_scheduler_top test passed");
        else
            $display("climate_threshold_scheduler_top test failed");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/cts_pkg.sv
hw/rtl/cts_sample_if.sv
hw/rtl/cts_result_if.sv
hw/rtl/cts_front.sv
hw/rtl/cts_queue.sv
hw/rtl/cts_back.sv
hw/rtl/climate_threshold_scheduler_top.sv
tb/sv/tb_climate_threshold_scheduler_top.sv
